@@ hdl/gbdh_pkg.sv @@
// Shared types and constants for the gyro bias, dead zone and heading core.
`default_nettype none
package gbdh_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_CALIBRATING      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_SCALE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_ZONE_FACTOR = 2'd2;

   localparam logic [15:0] DEAD_ZONE_RESET = 16'd4096;
   localparam logic signed [31:0] INT32_MAX_C = 32'sh7fff_ffff;
   localparam logic signed [31:0] INT32_MIN_C = 32'sh8000_0000;

   localparam logic FUNC_PROCESS = 1'b0;
   localparam logic FUNC_CLEAR   = 1'b1;

   typedef struct packed {
      logic              func;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_z;
      logic              accumulate;
      logic [15:0]       interval_ms;
   } req_type;

   typedef struct packed {
      logic signed [31:0] rate_x;
      logic signed [31:0] rate_y;
      logic signed [31:0] rate_z;
      logic [15:0]        heading_out;
      logic [15:0]        stat_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MUL,
      ST_RATE,
      ST_DIV_INIT,
      ST_DIV,
      ST_MEAN,
      ST_LIM,
      ST_COR,
      ST_HMUL,
      ST_HEAD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       mul_rate;
      logic       set_rate;
      logic       cnt_inc;
      logic       div_start;
      logic       div_step;
      logic       mean_upd;
      logic       mul_lim;
      logic       correct;
      logic       mul_head;
      logic       head_upd;
      logic       out_load;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic calibrating;
      logic count_nz;
      logic accumulate;
      logic div_last;
   } sts_type;

endpackage
`default_nettype wire

@@ hdl/gbdh_ctrl.sv @@
// Sequencer for the per-axis scale, calibrate, correct and heading steps.
`default_nettype none
module gbdh_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire gbdh_pkg::sts_type sts,
   output gbdh_pkg::cmd_type    cmd
);
   import gbdh_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       last_axis;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_axis = (axis_ff == 2'd2);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            axis_in = 2'd0;
            if (req_valid) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (sts.func == FUNC_CLEAR) state_in = ST_CLEAR;
            else state_in = ST_RATE;
         end
         ST_CLEAR: state_in = ST_OUT;
         ST_RATE: begin
            if (sts.calibrating) state_in = ST_DIV_INIT;
            else if (sts.count_nz) state_in = ST_LIM;
            else if (!last_axis) begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_MUL;
            end else if (sts.accumulate) state_in = ST_HMUL;
            else state_in = ST_OUT;
         end
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: if (sts.div_last) state_in = ST_MEAN;
         ST_MEAN, ST_COR: begin
            if (!last_axis) begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_MUL;
            end else if (!sts.calibrating && sts.accumulate) state_in = ST_HMUL;
            else state_in = ST_OUT;
         end
         ST_LIM:  state_in = ST_COR;
         ST_HMUL: state_in = ST_HEAD;
         ST_HEAD: state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.axis     = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE:  cmd.load = req_valid;
         ST_MUL: begin
            cmd.mul_rate = 1'b1;
            cmd.cnt_inc  = sts.calibrating && (sts.func == FUNC_PROCESS) &&
                           (axis_ff == 2'd0);
         end
         ST_CLEAR:    cmd.clear     = 1'b1;
         ST_RATE:     cmd.set_rate  = 1'b1;
         ST_DIV_INIT: cmd.div_start = 1'b1;
         ST_DIV:      cmd.div_step  = 1'b1;
         ST_MEAN:     cmd.mean_upd  = 1'b1;
         ST_LIM:      cmd.mul_lim   = 1'b1;
         ST_COR:      cmd.correct   = 1'b1;
         ST_HMUL:     cmd.mul_head  = 1'b1;
         ST_HEAD:     cmd.head_upd  = 1'b1;
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

@@ hdl/gbdh_dpath.sv @@
// Datapath: config registers, statistics, shared multiplier, divider, heading.
`default_nettype none
module gbdh_dpath #(
   parameter int HEADING_RANGE = 65535,
   parameter int COUNT_MAX     = 65535
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [gbdh_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [gbdh_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire gbdh_pkg::req_type                  req_data,
   input  wire gbdh_pkg::cmd_type                  cmd,
   output gbdh_pkg::sts_type                       sts,
   output gbdh_pkg::rsp_type                       rsp_data
);
   import gbdh_pkg::*;

   localparam logic [15:0] CountMax = 16'(COUNT_MAX);
   localparam logic signed [32:0] Range33 = 33'(HEADING_RANGE);
   localparam logic signed [17:0] Range18 = 18'(HEADING_RANGE);

   logic        cal_ff;
   logic [23:0] scale_ff;
   logic [15:0] dz_ff;

   req_type     req_ff;
   rsp_type     rsp_ff;

   logic signed [31:0] mean_ff [3];
   logic signed [31:0] min_ff  [3];
   logic signed [31:0] max_ff  [3];
   logic signed [31:0] rate_ff [3];
   logic [15:0]        cnt_ff;
   logic [15:0]        heading_ff, heading_in;

   logic signed [49:0] prod_ff, prod_in;
   logic               div_neg_ff;
   logic [15:0]        rem_ff;
   logic [31:0]        quo_ff;
   logic [4:0]         div_cnt_ff;

   logic signed [15:0] raw_sel;
   logic signed [31:0] rate_cur, mean_cur;
   logic signed [32:0] diff;
   logic [32:0]        diff_mag;
   logic signed [32:0] lim_base;
   logic signed [40:0] rnd_rate;
   logic signed [31:0] q_rate;
   logic signed [49:0] rnd_lim, lim, diff_w;
   logic               zero_v;
   logic signed [31:0] cor_val;
   logic [16:0]        rem_sh, rem_sub;
   logic               rem_ge;
   logic signed [32:0] q_signed;
   logic signed [33:0] mean_sum;
   logic signed [31:0] mean_new;
   logic signed [48:0] rnd_head;
   logic signed [32:0] d33;
   logic signed [17:0] delta, h18, hn;

   always_comb begin
      unique case (cmd.axis)
         2'd0:    raw_sel = req_ff.raw_x;
         2'd1:    raw_sel = req_ff.raw_y;
         default: raw_sel = req_ff.raw_z;
      endcase
   end

   assign rate_cur = rate_ff[cmd.axis];
   assign mean_cur = mean_ff[cmd.axis];
   assign diff     = {rate_cur[31], rate_cur} - {mean_cur[31], mean_cur};
   assign diff_mag = diff[32] ? -diff : diff;
   assign lim_base = diff[32] ? ({min_ff[cmd.axis][31], min_ff[cmd.axis]} -
                                 {mean_cur[31], mean_cur})
                              : ({max_ff[cmd.axis][31], max_ff[cmd.axis]} -
                                 {mean_cur[31], mean_cur});

   // shared multiplier input select, full 50-bit product
   always_comb begin
      prod_in = prod_ff;
      if (cmd.mul_rate)
         prod_in = raw_sel * $signed({1'b0, scale_ff});
      else if (cmd.mul_lim)
         prod_in = lim_base * $signed({1'b0, dz_ff});
      else if (cmd.mul_head)
         prod_in = rate_ff[2] * $signed({1'b0, req_ff.interval_ms});
   end

   // scaled rate, division by 256 toward zero then negate
   assign rnd_rate = prod_ff[40:0] + (prod_ff[40] ? 41'sd255 : 41'sd0);
   assign q_rate   = rnd_rate[39:8];

   // dead zone limit, division by 4096 toward zero
   assign rnd_lim = prod_ff + (prod_ff[49] ? 50'sd4095 : 50'sd0);
   assign lim     = rnd_lim >>> 12;
   assign diff_w  = 50'(diff);
   assign zero_v  = diff[32] ? (diff_w > lim) : (diff_w < lim);

   always_comb begin
      if (zero_v) cor_val = '0;
      else if (!diff[32] && diff[31]) cor_val = INT32_MAX_C;
      else if (diff[32] && !diff[31]) cor_val = INT32_MIN_C;
      else cor_val = diff[31:0];
   end

   // restoring divider step
   assign rem_sh  = {rem_ff, quo_ff[31]};
   assign rem_ge  = rem_sh >= {1'b0, cnt_ff};
   assign rem_sub = rem_sh - {1'b0, cnt_ff};

   assign q_signed = div_neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign mean_sum = 34'(mean_cur) + 34'(q_signed);

   always_comb begin
      if (mean_sum > 34'(INT32_MAX_C)) mean_new = INT32_MAX_C;
      else if (mean_sum < 34'(INT32_MIN_C)) mean_new = INT32_MIN_C;
      else mean_new = mean_sum[31:0];
   end

   // heading step, division by 65536 toward zero, clamp and wrap
   assign rnd_head = prod_ff[48:0] + (prod_ff[48] ? 49'sd65535 : 49'sd0);
   assign d33      = rnd_head[48:16];
   assign h18      = $signed({2'b00, heading_ff});

   always_comb begin
      if (d33 > Range33) delta = Range18;
      else if (d33 < -Range33) delta = -Range18;
      else delta = d33[17:0];
      priority if (delta < 0 && -delta > h18) hn = Range18 + h18 + delta;
      else if (delta > 0 && (Range18 - h18) < delta) hn = delta - (Range18 - h18);
      else hn = h18 + delta;
      heading_in = hn[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff     <= 1'b0;
         scale_ff   <= '0;
         dz_ff      <= DEAD_ZONE_RESET;
         cnt_ff     <= '0;
         heading_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            mean_ff[i] <= '0;
            min_ff[i]  <= INT32_MAX_C;
            max_ff[i]  <= INT32_MIN_C;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_CALIBRATING:      cal_ff   <= csr_wdata[0];
               CSR_GYRO_SCALE:       scale_ff <= csr_wdata[23:0];
               CSR_DEAD_ZONE_FACTOR: dz_ff    <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.clear) begin
            cnt_ff <= '0;
            for (int i = 0; i < 3; i++) begin
               mean_ff[i] <= '0;
               min_ff[i]  <= INT32_MAX_C;
               max_ff[i]  <= INT32_MIN_C;
            end
         end
         if (cmd.cnt_inc && cnt_ff < CountMax) cnt_ff <= cnt_ff + 16'd1;
         if (cmd.mean_upd) begin
            mean_ff[cmd.axis] <= mean_new;
            if (rate_cur > max_ff[cmd.axis]) max_ff[cmd.axis] <= rate_cur;
            if (rate_cur < min_ff[cmd.axis]) min_ff[cmd.axis] <= rate_cur;
         end
         if (cmd.head_upd) heading_ff <= heading_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      prod_ff <= prod_in;
      if (cmd.clear) begin
         for (int i = 0; i < 3; i++) rate_ff[i] <= '0;
      end
      if (cmd.set_rate) rate_ff[cmd.axis] <= -q_rate;
      if (cmd.correct)  rate_ff[cmd.axis] <= cor_val;
      if (cmd.div_start) begin
         div_neg_ff <= diff[32];
         quo_ff     <= diff_mag[31:0];
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         // remainder stays below the count, so 16 bits hold it
         rem_ff     <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
         quo_ff     <= {quo_ff[30:0], rem_ge};
         div_cnt_ff <= div_cnt_ff + 5'd1;
      end
      if (cmd.out_load) begin
         rsp_ff.rate_x      <= rate_ff[0];
         rsp_ff.rate_y      <= rate_ff[1];
         rsp_ff.rate_z      <= rate_ff[2];
         rsp_ff.heading_out <= heading_ff;
         rsp_ff.stat_count  <= cnt_ff;
      end
   end

   assign sts.func        = req_ff.func;
   assign sts.calibrating = cal_ff;
   assign sts.count_nz    = (cnt_ff != 16'd0);
   assign sts.accumulate  = req_ff.accumulate;
   assign sts.div_last    = (div_cnt_ff == 5'd31);
   assign rsp_data        = rsp_ff;

endmodule
`default_nettype wire

@@ hdl/gyro_bias_deadzone_heading_core.sv @@
// Gyro bias calibration, dead zone correction and heading integration core.
//
// Request channel (req_valid/req_ready/req_data) takes one three-axis raw
// sample or a statistics-clear command; response channel (rsp_valid/
// rsp_ready/rsp_data) returns one result per request: three Q16.16 rates,
// the heading and the calibration sample count.
// Configuration writes through csr_we/csr_index/csr_wdata while idle.
// The block does not enforce this; the user must keep to it. One request
// is processed at a time by a sequencer over a shared multiplier. Per
// axis: a multiply and a rate step scale the sample, then in calibrating
// mode the 32-step restoring divider updates the running mean, or, once
// samples are counted, a limit multiply and a correct step apply the dead
// zone. Outside calibrating mode a multiply and a step advance the heading
// when accumulating. The divider sets the throughput in calibrating mode.
// A finished result waits in an output register while the next request
// is taken; a stalled receiver holds the sequencer only at its last step.
// Reset clears statistics, heading and configuration registers (dead zone factor 1.0).
`default_nettype none
module gyro_bias_deadzone_heading_core #(
   parameter int HEADING_RANGE = 65535,
   parameter int COUNT_MAX     = 65535
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire gbdh_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output gbdh_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [gbdh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [gbdh_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gbdh_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gbdh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gbdh_dpath #(
      .HEADING_RANGE (HEADING_RANGE),
      .COUNT_MAX     (COUNT_MAX)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
